// ===== rtl/mpam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpam_pkg
// Shared types and constants of the reply matcher.
// ----------------------------------------------------------------------------
package mpam_pkg;

  localparam int RespDepthDefault = 32;

  localparam logic [7:0] SYNC1_BYTE = 8'h75;
  localparam logic [7:0] SYNC2_BYTE = 8'h65;
  localparam logic [7:0] ACK_DESC   = 8'hF1;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_DSET    = 3'd0,
    CFG_CMD     = 3'd1,
    CFG_WANT    = 3'd2,
    CFG_TIMEOUT = 3'd3,
    CFG_MAXLEN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_SYNC2 = 3'd2,
    PH_DSET  = 3'd3,
    PH_LEN   = 3'd4,
    PH_BODY  = 3'd5,
    PH_DRAIN = 3'd6
  } phase_t;

  // Emission request from parser to result sequencer.
  typedef struct packed {
    logic       go;
    logic [1:0] status;
    logic       with_resp;
  } emit_req_t;

endpackage : mpam_pkg
`default_nettype wire

// ===== rtl/mip_packet_ack_response_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mip_packet_ack_response_matcher
// Deframes received link packets, checks the 8-bit Fletcher-style checksum (sums mod 256) and collects ACK/response.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one event per transfer (tuser = kind: byte, tick or
// start; tdata = received byte). m_axis returns the transaction result: one
// transfer for OK/NACK/TIMEOUT, or one per captured response byte, tlast on
// the final one. cfg writes the five registers by index while idle.
// Throughput: one input transfer per cycle while no result is requested or being emitted.
// Results: the first result of a transaction passes the request register, the
// sequencer start, store read and output load after the ending transfer.
// A further result is read once the one before is loaded, each byte from the
// response store memory (synchronous read). Hold off input from the cycle after
// the ending transfer until the last result has entered the output stage.
// The response bytes are written into that memory as they arrive.
// Reset: the configuration registers return to their defaults, the block goes idle
// and ignores everything but a start. The response store is not cleared.
// Stall: the output stage holds the current result while m_axis_tready is
// low; the next result waits in the store read stage, input stays held off.
// ----------------------------------------------------------------------------
module mip_packet_ack_response_matcher #(
  parameter int RESP_DEPTH = mpam_pkg::RespDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [1:0] status, [9:2] ACK code,
                                           // [17:10] echoed command,
                                           // [25:18] response descriptor,
                                           // [32:26] response length,
                                           // [40:33] data_byte, [47:41] zero
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mpam_pkg::*;

  localparam int AW = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(RESP_DEPTH);

  // configuration
  logic [7:0]  expected_desc_set, command_desc;
  logic        want_response;
  logic [15:0] timeout_ticks;
  logic [9:0]  max_packet_len;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_desc_set <= 8'd1;
      command_desc      <= 8'd0;
      want_response     <= 1'b0;
      timeout_ticks     <= 16'd1000;
      max_packet_len    <= 10'd512;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DSET:    expected_desc_set <= cfg_data[7:0];
        CFG_CMD:     command_desc      <= cfg_data[7:0];
        CFG_WANT:    want_response     <= cfg_data[0];
        CFG_TIMEOUT: timeout_ticks     <= cfg_data;
        CFG_MAXLEN:  max_packet_len    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // response store
  logic [7:0] store [RESP_DEPTH];
  logic       st_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [7:0] st_wd, st_rd;
  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    st_rd <= store[st_ra];
  end

  // parser state
  phase_t      phase;
  logic [7:0]  pkt_dset, pay_len, fbl, fdesc, ck1, s_lo, s_hi, flen, fecho;
  logic [8:0]  bcnt, fpos;
  logic        stopped, capturing, ack_seen;
  logic [16:0] p_ack;
  logic [15:0] c_ack;
  logic [15:0] p_resp, c_resp;
  logic [15:0] ticks;

  // emission sequencer
  logic        busy;        // emitting results
  logic [6:0]  e_n, e_k;
  logic [1:0]  e_status;
  logic [6:0]  e_len;
  logic [7:0]  e_desc;
  logic        rd_pend;     // st_rd valid for output stage
  logic        rd_last;

  emit_req_t req;

  logic acc;
  // Hold off input while a request is on its way to the sequencer too.
  assign s_axis_tready = !busy && !req.go;
  assign acc = s_axis_tvalid && s_axis_tready;

  // one add step
  function automatic logic [15:0] addsum(logic [7:0] lo, logic [7:0] hi, logic [7:0] b);
    logic [7:0] nl;
    nl = lo + b;
    return {hi + nl, nl};
  endfunction

  logic [15:0] tick_inc;
  logic [8:0]  remain;
  logic        ok, had_ack;
  logic [6:0]  rl;
  logic [9:0]  whole;
  assign tick_inc = ticks + 16'd1;
  assign remain   = {1'b0, pay_len} - bcnt;
  assign whole    = {2'b00, s_axis_tdata} + 10'd6;
  assign had_ack  = p_ack[16];
  assign ok = (ck1 == s_lo) && (s_axis_tdata == s_hi) && (pkt_dset == expected_desc_set)
              && (pay_len >= 8'd2);
  assign rl = (flen - 8'd2 > {1'b0, DEPTH7}) ? DEPTH7 : 7'(flen - 8'd2);

  always_ff @(posedge clk) begin
    phase_t    phase_next;
    emit_req_t req_next;
    logic      st_we_next;
    phase_next = phase;
    req_next   = '0;
    st_we_next = 1'b0;
    if (rst) begin
      phase_next = PH_IDLE;
      ticks <= '0; c_ack <= 16'h00FF; c_resp <= '0; ack_seen <= 1'b0;
      p_ack <= '0; p_resp <= '0; bcnt <= '0; fbl <= '0; stopped <= 1'b0;
      s_lo <= '0; s_hi <= '0; fdesc <= '0; capturing <= 1'b0; fpos <= '0;
    end else if (acc) begin
      case (kind_t'(s_axis_tuser))
        KIND_START: begin
          ticks <= '0; c_ack <= 16'h00FF; c_resp <= '0; ack_seen <= 1'b0;
          p_ack <= '0; p_resp <= '0; bcnt <= '0; fbl <= '0; stopped <= 1'b0;
          capturing <= 1'b0; fpos <= '0; fdesc <= '0;
          phase_next = PH_SYNC1;
          if (timeout_ticks == 16'd0) begin
            req_next = '{go: 1'b1, status: ST_TIMEOUT, with_resp: 1'b0};
            phase_next = PH_IDLE;
          end
        end
        KIND_TICK: if (phase != PH_IDLE) begin
          ticks <= tick_inc;
          if (tick_inc >= timeout_ticks) begin
            req_next = '{go: 1'b1, status: ST_TIMEOUT, with_resp: 1'b0};
            phase_next = PH_IDLE;
          end
        end
        KIND_BYTE: begin
          case (phase)
            PH_SYNC1: if (s_axis_tdata == SYNC1_BYTE) begin
              {s_hi, s_lo} <= addsum(8'd0, 8'd0, s_axis_tdata);
              phase_next = PH_SYNC2;
            end
            PH_SYNC2: if (s_axis_tdata == SYNC2_BYTE) begin
              {s_hi, s_lo} <= addsum(s_lo, s_hi, s_axis_tdata);
              phase_next = PH_DSET;
            end else phase_next = PH_SYNC1;
            PH_DSET: begin
              pkt_dset <= s_axis_tdata;
              {s_hi, s_lo} <= addsum(s_lo, s_hi, s_axis_tdata);
              phase_next = PH_LEN;
            end
            PH_LEN: begin
              pay_len <= s_axis_tdata;
              {s_hi, s_lo} <= addsum(s_lo, s_hi, s_axis_tdata);
              fbl <= '0; fpos <= '0; fdesc <= '0; stopped <= 1'b0; capturing <= 1'b0;
              p_ack <= '0; p_resp <= '0; flen <= '0;
              if (max_packet_len < 10'd8 || whole > max_packet_len) begin
                bcnt <= {1'b0, s_axis_tdata} + 9'd2;
                phase_next = PH_DRAIN;
              end else begin
                bcnt <= '0;
                phase_next = PH_BODY;
              end
            end
            PH_DRAIN: begin
              if (bcnt > 9'd1) bcnt <= bcnt - 9'd1;
              else begin bcnt <= '0; phase_next = PH_SYNC1; end
            end
            PH_BODY: begin
              if (bcnt < {1'b0, pay_len}) begin
                {s_hi, s_lo} <= addsum(s_lo, s_hi, s_axis_tdata);
                bcnt <= bcnt + 9'd1;
                if (!stopped) begin
                  if (fbl == 8'd0) begin
                    if (remain < 9'd2 || s_axis_tdata < 8'd2 || {1'b0, s_axis_tdata} > remain)
                      stopped <= 1'b1;
                    else begin
                      flen <= s_axis_tdata; fbl <= s_axis_tdata - 8'd1; fpos <= 9'd1;
                    end
                  end else begin
                    fpos <= fpos + 9'd1; fbl <= fbl - 8'd1;
                    if (fpos == 9'd1) begin
                      fdesc <= s_axis_tdata;
                      capturing <= (s_axis_tdata != ACK_DESC) && want_response
                                   && !c_resp[15] && !p_resp[15];
                      if (s_axis_tdata != ACK_DESC && want_response && !c_resp[15]
                          && !p_resp[15]) begin
                        p_resp <= {1'b1, rl, s_axis_tdata};
                      end
                    end else if (fdesc == ACK_DESC) begin
                      if (flen >= 8'd4) begin
                        if (fpos == 9'd2) fecho <= s_axis_tdata;
                        else if (fpos == 9'd3 && fecho == command_desc)
                          p_ack <= {1'b1, fecho, s_axis_tdata};
                      end
                    end else if (capturing && (fpos - 9'd2) < 9'(RESP_DEPTH)) begin
                      st_we_next = 1'b1; st_wa <= AW'(fpos - 9'd2); st_wd <= s_axis_tdata;
                    end
                  end
                end
              end else if (bcnt == {1'b0, pay_len}) begin
                ck1 <= s_axis_tdata; bcnt <= bcnt + 9'd1;
              end else begin
                phase_next = PH_SYNC1;
                p_ack <= '0; p_resp <= '0;
                if (ok) begin
                  if (had_ack) begin c_ack <= p_ack[15:0]; ack_seen <= 1'b1; end
                  if (p_resp[15]) c_resp <= p_resp;
                  if (had_ack || ack_seen) begin
                    if ((had_ack ? p_ack[7:0] : c_ack[7:0]) != 8'd0) begin
                      req_next = '{go: 1'b1, status: ST_NACK, with_resp: 1'b0};
                      phase_next = PH_IDLE;
                    end else if (!want_response) begin
                      req_next = '{go: 1'b1, status: ST_OK, with_resp: 1'b0};
                      phase_next = PH_IDLE;
                    end else if (c_resp[15] || p_resp[15]) begin
                      req_next = '{go: 1'b1, status: ST_OK, with_resp: 1'b1};
                      phase_next = PH_IDLE;
                    end
                  end
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
    phase <= phase_next;
    req   <= req_next;
    st_we <= st_we_next;
  end

  // result sequencer: a store read waits for the last one to load, output stage with hold
  logic [6:0] clen;
  logic       out_free;
  logic       out_load;
  assign clen = req.with_resp ? c_resp[14:8] : 7'd0;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = rd_pend && out_free;

  logic [1:0]  o_status;
  logic [7:0]  o_code, o_echo, o_desc, o_data;
  logic [6:0]  o_len;
  assign st_ra = AW'(e_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; rd_pend <= 1'b0; m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (req.go) begin
        busy <= 1'b1; e_k <= '0; e_status <= req.status;
        e_len <= clen;
        e_desc <= req.with_resp ? c_resp[7:0] : 8'd0;
        e_n <= (clen == 7'd0) ? 7'd1 : ((clen > DEPTH7) ? DEPTH7 : clen);
      end else if (busy && !rd_pend) begin
        rd_pend <= 1'b1; rd_last <= (e_k + 7'd1 == e_n);
      end else if (out_load) begin
        o_status <= e_status; o_code <= c_ack[7:0]; o_echo <= c_ack[15:8];
        o_desc <= e_desc; o_len <= e_len;
        o_data <= (e_len != 7'd0) ? st_rd : 8'd0;
        m_axis_tlast <= rd_last;
        rd_pend <= 1'b0;
        if (rd_last) busy <= 1'b0;
        else e_k <= e_k + 7'd1;
      end
    end
  end

  assign m_axis_tdata = {7'd0, o_data, o_len, o_desc, o_echo, o_code, o_status};
endmodule : mip_packet_ack_response_matcher
`default_nettype wire
